// ===== rtl/rso_pkg.sv =====
// rso_pkg: shared constants, config register codes and item structs for the
// rounded square overlay. No dependencies.
package rso_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
	localparam int OFS_W       = SIDE_W + 1;
	localparam int PCT_W       = 6;
	localparam int PCT_MAX     = 50;
	localparam int RAD_W       = $clog2(MAX_SIDE / 2 + 1);
	localparam int PROD_W      = SIDE_W + PCT_W;
	// floor(n / 100) as (n * RECIP) >> RECIP_SHIFT, exact for n below 2**PROD_W
	localparam int RECIP       = 5243;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int REC_W       = PROD_W + RECIP_W;
	localparam int SQ_W        = 2 * RAD_W;
	localparam int SUM_W       = SQ_W + 1;
	localparam int CH_W        = 8;

	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 9;
	localparam int SETTLE_CYC  = 4;
	localparam int SETTLE_W    = $clog2(SETTLE_CYC + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 4'd0,
		REG_IMAGE_HEIGHT   = 4'd1,
		REG_SQUARE_SIZE    = 4'd2,
		REG_RADIUS_PERCENT = 4'd3,
		REG_FILL_RED       = 4'd4,
		REG_FILL_GREEN     = 4'd5,
		REG_FILL_BLUE      = 4'd6,
		REG_ERASE_MODE     = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
		logic [CH_W-1:0] in_alpha;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
		logic            frame_end;
	} pix_out_t;

	// derived geometry, settled by the rso_cfg pipeline after a register write
	typedef struct packed {
		logic [SIDE_W-1:0]        w_last;
		logic [SIDE_W-1:0]        h_last;
		logic [SIDE_W-1:0]        side;
		logic signed [OFS_W-1:0]  sx;
		logic signed [OFS_W-1:0]  sy;
		logic [RAD_W-1:0]         rad;
		logic [SIDE_W-1:0]        hi;
		logic [SQ_W-1:0]          rad2;
	} geom_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            erase;
	} fill_t;

	typedef struct packed {
		pix_in_t          pix;
		logic             in_square;
		logic [RAD_W-1:0] dx;
		logic [RAD_W-1:0] dy;
		logic             frame_end;
	} q_item_t;

endpackage

// ===== rtl/rso_cfg.sv =====
// rso_cfg: configuration registers and the registered pipeline that derives
// square offsets, corner radius and radius squared. Uses rso_pkg.
module rso_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [rso_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rso_pkg::CFG_DATA_W-1:0] cfg_data,
	output rso_pkg::geom_t                 geom,
	output rso_pkg::fill_t                 fill,
	output logic                           busy
);
	import rso_pkg::*;

	logic [SIDE_W-1:0]   width_q, height_q, size_q;
	logic [PCT_W-1:0]    pct_q;
	logic [CH_W-1:0]     red_q, green_q, blue_q;
	logic                erase_q;
	logic [SETTLE_W-1:0] settle_q;

	logic [SIDE_W-1:0]        w_c, h_c, s_c;
	logic [PCT_W-1:0]         p_c;
	logic signed [OFS_W-1:0]  dw_c, dh_c, tw_c, th_c;

	logic [SIDE_W-1:0]        w_last_q, h_last_q, side_q, hi_q;
	logic signed [OFS_W-1:0]  sx_q, sy_q;
	logic [PROD_W-1:0]        prod_q;
	logic [REC_W-1:0]         rec_q;
	logic [RAD_W-1:0]         rad_q;
	logic [SQ_W-1:0]          rad2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(196);
			height_q <= SIDE_W'(196);
			size_q   <= SIDE_W'(196);
			pct_q    <= '0;
			red_q    <= '0;
			green_q  <= '0;
			blue_q   <= '0;
			erase_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    width_q  <= cfg_data[SIDE_W-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data[SIDE_W-1:0];
				REG_SQUARE_SIZE:    size_q   <= cfg_data[SIDE_W-1:0];
				REG_RADIUS_PERCENT: pct_q    <= cfg_data[PCT_W-1:0];
				REG_FILL_RED:       red_q    <= cfg_data[CH_W-1:0];
				REG_FILL_GREEN:     green_q  <= cfg_data[CH_W-1:0];
				REG_FILL_BLUE:      blue_q   <= cfg_data[CH_W-1:0];
				REG_ERASE_MODE:     erase_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input stalls until the derived pipeline has caught up with a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(SETTLE_CYC);
		end else if (cfg_valid) begin
			settle_q <= SETTLE_W'(SETTLE_CYC);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIDE_W'(1);
		else if (v > SIDE_W'(MAX_SIDE))
			r = SIDE_W'(MAX_SIDE);
		return r;
	endfunction

	always_comb begin
		w_c  = clamp_side(width_q);
		h_c  = clamp_side(height_q);
		s_c  = clamp_side(size_q);
		p_c  = (pct_q > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct_q;
		dw_c = $signed({1'b0, w_c}) - $signed({1'b0, s_c});
		dh_c = $signed({1'b0, h_c}) - $signed({1'b0, s_c});
		// halve with truncation toward zero
		tw_c = dw_c + $signed({{(OFS_W-1){1'b0}}, dw_c[OFS_W-1]});
		th_c = dh_c + $signed({{(OFS_W-1){1'b0}}, dh_c[OFS_W-1]});
	end

	always_ff @(posedge clk) begin
		w_last_q <= w_c - 1'b1;
		h_last_q <= h_c - 1'b1;
		side_q   <= s_c;
		sx_q     <= tw_c >>> 1;
		sy_q     <= th_c >>> 1;
		prod_q   <= PROD_W'(s_c * p_c);
		rec_q    <= REC_W'(prod_q * RECIP_W'(RECIP));
		rad_q    <= rec_q[RECIP_SHIFT +: RAD_W];
		hi_q     <= side_q - SIDE_W'(rad_q);
		rad2_q   <= SQ_W'(rad_q * rad_q);
	end

	always_comb begin
		geom.w_last = w_last_q;
		geom.h_last = h_last_q;
		geom.side   = side_q;
		geom.sx     = sx_q;
		geom.sy     = sy_q;
		geom.rad    = rad_q;
		geom.hi     = hi_q;
		geom.rad2   = rad2_q;
		fill.red    = red_q;
		fill.green  = green_q;
		fill.blue   = blue_q;
		fill.erase  = erase_q;
		busy        = (settle_q != '0);
	end

	a_write_holds_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> busy)
		else $error("config write did not hold off the input");

endmodule

// ===== rtl/rso_front.sv =====
// rso_front: accepts pixels, tracks column and row, and classifies each pixel
// against the square and its corners. Uses rso_pkg.
module rso_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	input  rso_pkg::pix_in_t pix,
	output logic             pix_stall,
	input  logic             busy,
	input  rso_pkg::geom_t   geom,
	input  logic             q_full,
	output logic             q_push,
	output rso_pkg::q_item_t q_item
);
	import rso_pkg::*;

	logic [SIDE_W-1:0]  col_q, row_q;
	logic               last_col, last_row;
	logic signed [OFS_W:0] lx, ly;
	logic               in_x, in_y;
	logic [SIDE_W-1:0]  ux, uy;

	function automatic logic [RAD_W-1:0] corner_dist(input logic [SIDE_W-1:0] u,
		input logic [RAD_W-1:0] rad, input logic [SIDE_W-1:0] hi);
		logic [RAD_W-1:0] d;
		d = '0;
		if (u < SIDE_W'(rad))
			d = RAD_W'(SIDE_W'(rad) - u);
		else if (u >= hi)
			d = RAD_W'(u - hi + 1'b1);
		return d;
	endfunction

	always_comb begin
		pix_stall = busy || q_full;
		q_push    = pix_valid && !pix_stall;
		last_col  = (col_q >= geom.w_last);
		last_row  = (row_q >= geom.h_last);
		lx = $signed({2'b00, col_q}) - $signed({geom.sx[OFS_W-1], geom.sx});
		ly = $signed({2'b00, row_q}) - $signed({geom.sy[OFS_W-1], geom.sy});
		in_x = !lx[OFS_W] && (lx[OFS_W-1:0] < {1'b0, geom.side});
		in_y = !ly[OFS_W] && (ly[OFS_W-1:0] < {1'b0, geom.side});
		ux = lx[SIDE_W-1:0];
		uy = ly[SIDE_W-1:0];
		q_item.pix       = pix;
		q_item.in_square = in_x && in_y;
		q_item.dx        = corner_dist(ux, geom.rad, geom.hi);
		q_item.dy        = corner_dist(uy, geom.rad, geom.hi);
		q_item.frame_end = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rso_queue.sv =====
// rso_queue: short queue of classified items between front and back.
// Uses rso_pkg.
module rso_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rso_pkg::q_item_t push_item,
	input  logic             pop,
	output rso_pkg::q_item_t head,
	output logic             full,
	output logic             empty
);
	import rso_pkg::*;

	q_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_comb begin
		full  = (cnt_q == QCNT_W'(QDEPTH));
		empty = (cnt_q == '0);
		head  = mem_q[rd_q];
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

// ===== rtl/rso_back.sv =====
// rso_back: squares the corner distances, decides coverage and drives the
// registered result. Uses rso_pkg.
module rso_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  rso_pkg::q_item_t  q_head,
	output logic              q_pop,
	input  rso_pkg::geom_t    geom,
	input  rso_pkg::fill_t    fill,
	output logic              res_valid,
	input  logic              res_stall,
	output rso_pkg::pix_out_t res
);
	import rso_pkg::*;

	logic              v_s1, v_s2;
	pix_in_t           pix_s1;
	logic              in_square_s1, fe_s1;
	logic [SQ_W-1:0]   dx2_s1, dy2_s1;
	pix_out_t          res_s2, res_c;
	logic              adv1, adv2, covered;
	logic [SUM_W-1:0]  dist2;

	always_comb begin
		adv2    = !v_s2 || !res_stall;
		adv1    = !v_s1 || adv2;
		q_pop   = adv1 && !q_empty;
		dist2   = {1'b0, dx2_s1} + {1'b0, dy2_s1};
		covered = in_square_s1 && (dist2 <= SUM_W'(geom.rad2));
		if (!covered) begin
			res_c.out_red   = pix_s1.in_red;
			res_c.out_green = pix_s1.in_green;
			res_c.out_blue  = pix_s1.in_blue;
			res_c.out_alpha = pix_s1.in_alpha;
		end else if (fill.erase) begin
			res_c.out_red   = '0;
			res_c.out_green = '0;
			res_c.out_blue  = '0;
			res_c.out_alpha = '0;
		end else begin
			res_c.out_red   = fill.red;
			res_c.out_green = fill.green;
			res_c.out_blue  = fill.blue;
			res_c.out_alpha = '1;
		end
		res_c.frame_end = fe_s1;
		res_valid       = v_s2;
		res             = res_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= !q_empty;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pix_s1       <= q_head.pix;
			in_square_s1 <= q_head.in_square;
			fe_s1        <= q_head.frame_end;
			dx2_s1       <= SQ_W'(q_head.dx * q_head.dx);
			dy2_s1       <= SQ_W'(q_head.dy * q_head.dy);
		end
		if (adv2)
			res_s2 <= res_c;
	end

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |=> (v_s1 && $stable(dx2_s1) && $stable(fe_s1)))
		else $error("stage one item lost while the result was stalled");

endmodule

// ===== rtl/rounded_square_overlay_unit.sv =====
// rounded_square_overlay_unit: top level of the rounded square overlay.
// Instantiates rso_cfg, rso_front, rso_queue and rso_back; uses rso_pkg.
//
//  channel   direction  handshake              payload
//  pix       in         pix_valid / pix_stall  pix (pix_in_t: rgba)
//  res       out        res_valid / res_stall  res (pix_out_t: rgba, frame_end)
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per clock sustained while res is not stalled and nothing settles;
// an accepted item passes the queue, the square stage and the output register
// the input stalls after reset and after every register write while the
// offset / radius / radius-squared pipeline settles
// a stalled result backs up into the four-entry queue; the input stalls only
// once that queue is full
// cfg_ready is always high; writes belong between frames with nothing in flight
module rounded_square_overlay_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  rso_pkg::pix_in_t               pix,
	output logic                           res_valid,
	input  logic                           res_stall,
	output rso_pkg::pix_out_t              res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rso_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rso_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rso_pkg::*;

	geom_t   geom;
	fill_t   fill;
	logic    busy;
	logic    q_push, q_pop, q_full, q_empty;
	q_item_t q_item, q_head;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// configuration and derived geometry
	rso_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.fill      (fill),
		.busy      (busy)
	);

	// front: raster position and corner classification
	rso_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_stall (pix_stall),
		.busy      (busy),
		.geom      (geom),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	// decoupling queue so front and back stall on their own
	rso_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: distance test, fill or erase, output register
	rso_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.geom      (geom),
		.fill      (fill),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== dv/rounded_square_overlay_unit_tb.sv =====
// rounded_square_overlay_unit_tb: self-checking testbench for the rounded square overlay.
// Uses rso_pkg and rounded_square_overlay_unit. It predicts every pixel in the testbench
// and compares each result with the oldest prediction.
module rounded_square_overlay_unit_tb;
	import rso_pkg::*;

	localparam int PERCENT_SCALE     = 100;
	localparam logic [CH_W-1:0] OPAQUE = 8'hFF;
	localparam int FIRST_SPARE_INDEX = REG_ERASE_MODE + 1;
	localparam int PHASES            = 14;
	localparam int SHOWN_FAILURES    = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_in_t               pix       = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	pix_out_t              res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// testbench copy of the registers, at their reset values
	logic [SIDE_W-1:0] width_set  = 9'd196;
	logic [SIDE_W-1:0] height_set = 9'd196;
	logic [SIDE_W-1:0] side_set   = 9'd196;
	logic [PCT_W-1:0]  pct_set    = '0;
	logic [CH_W-1:0]   red_set    = '0;
	logic [CH_W-1:0]   green_set  = '0;
	logic [CH_W-1:0]   blue_set   = '0;
	logic              erase_set  = 1'b0;

	// raster position of the next pixel
	int column_pos = 0;
	int row_pos    = 0;

	pix_in_t  pix_pending[$];
	pix_out_t pixel_expect[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int failures       = 0;
	int pixels_sent    = 0;
	int pixels_checked = 0;
	int covered_pixels = 0;
	int frame_ends     = 0;
	int settings_used  = 1;

	rounded_square_overlay_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// zero reads as one, anything past the largest side saturates
	function automatic int clamp_side(logic [SIDE_W-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > MAX_SIDE)
			return MAX_SIDE;
		return int'(v);
	endfunction

	// paint one pixel at the current raster position, then step the counters
	function automatic pix_out_t paint_pixel(pix_in_t p);
		int w, h, s, pct, rad, inner, sx, sy, lx, ly, nx, ny, dx, dy;
		logic last_col, last_row, covered;
		pix_out_t o;
		w     = clamp_side(width_set);
		h     = clamp_side(height_set);
		s     = clamp_side(side_set);
		pct   = (int'(pct_set) > PCT_MAX) ? PCT_MAX : int'(pct_set);
		rad   = (s * pct) / PERCENT_SCALE;
		inner = s - 2 * rad;
		// offsets round toward zero, so a square wider than the image starts left of it
		sx    = (w - s) / 2;
		sy    = (h - s) / 2;
		last_col = column_pos >= w - 1;
		last_row = row_pos >= h - 1;
		covered  = 1'b0;
		if (column_pos >= sx && column_pos < sx + s && row_pos >= sy && row_pos < sy + s) begin
			lx = column_pos - sx;
			ly = row_pos - sy;
			// nearest point of the inner rectangle, i.e. the clamped corner centre
			nx = (lx < rad) ? rad : ((lx >= rad + inner) ? rad + inner - 1 : lx);
			ny = (ly < rad) ? rad : ((ly >= rad + inner) ? rad + inner - 1 : ly);
			dx = lx - nx;
			dy = ly - ny;
			covered = (dx * dx + dy * dy) <= rad * rad;
		end
		if (!covered)
			o = '{p.in_red, p.in_green, p.in_blue, p.in_alpha, 1'b0};
		else if (erase_set)
			o = '0;
		else
			o = '{red_set, green_set, blue_set, OPAQUE, 1'b0};
		o.frame_end = last_col && last_row;
		covered_pixels += covered;
		frame_ends     += o.frame_end;
		// a counter left past a shrunken dimension wraps on its next pixel
		if (last_col) begin
			column_pos = 0;
			row_pos    = last_row ? 0 : row_pos + 1;
		end else begin
			column_pos++;
		end
		return o;
	endfunction

	function automatic void store_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_IMAGE_WIDTH:    width_set  = d;
			REG_IMAGE_HEIGHT:   height_set = d;
			REG_SQUARE_SIZE:    side_set   = d;
			REG_RADIUS_PERCENT: pct_set    = d[PCT_W-1:0];
			REG_FILL_RED:       red_set    = d[CH_W-1:0];
			REG_FILL_GREEN:     green_set  = d[CH_W-1:0];
			REG_FILL_BLUE:      blue_set   = d[CH_W-1:0];
			REG_ERASE_MODE:     erase_set  = d[0];
			default: ;
		endcase
	endfunction

	function automatic void flag_failure(string msg);
		failures++;
		if (failures <= SHOWN_FAILURES)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// pixel driver: reloads whenever the current item has gone or nothing is offered
	always @(posedge clk) begin
		if (pix_valid && !pix_stall) begin
			pixel_expect.push_back(paint_pixel(pix));
			pixels_sent++;
		end
		if (!pix_valid || !pix_stall) begin
			if (arst_n && pix_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pix       <= pix_pending.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// result monitor and random back-pressure
	always @(posedge clk) begin
		pix_out_t want;
		res_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
		if (arst_n && res_valid && !res_stall) begin
			pixels_checked++;
			if (pixel_expect.size() == 0) begin
				flag_failure($sformatf("result with nothing expected: rgba %h %h %h %h end %b",
					res.out_red, res.out_green, res.out_blue, res.out_alpha, res.frame_end));
			end else begin
				want = pixel_expect.pop_front();
				if (res !== want)
					flag_failure($sformatf(
						"pixel mismatch: expected rgba %h %h %h %h end %b, got %h %h %h %h end %b",
						want.out_red, want.out_green, want.out_blue, want.out_alpha,
						want.frame_end, res.out_red, res.out_green, res.out_blue,
						res.out_alpha, res.frame_end));
			end
		end
	end

	// settle at a falling edge so the driver's reload cannot race the check
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pix_pending.size() != 0 || pix_valid || pixel_expect.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		store_setting(idx, d);
	endtask

	task automatic queue_pixels(int count);
		for (int k = 0; k < count; k++)
			pix_pending.push_back(pix_in_t'($urandom));
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] nxt [8];
		logic [31:0] corner_values [12];
		int count;
		corner_values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h8080_8080, 32'h0101_0101, 32'h7F7F_7F7F, 32'hFEFE_FEFE,
			32'hFF00_FF00, 32'h00FF_00FF, 32'h0000_FFFF, 32'hFFFF_0000};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			// receiver-stall heavy first, then sender-idle heavy, then full rate
			if (ph < 6) begin
				send_idle_pct  = 29;
				recv_stall_pct = 75;
			end else if (ph < 10) begin
				send_idle_pct  = 75;
				recv_stall_pct = 29;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end

			// phase 0 runs on the reset values, every later one rewrites all registers
			if (ph > 0) begin
				wait_drained();
				case (ph)
					// one whole 4x3 frame, square overhanging the bottom, full rounding
					1: nxt = '{9'd4, 9'd3, 9'd4, 9'd50, 9'h3C, 9'hC3, 9'h99, 9'd0};
					// zero dimensions read as one, so every pixel ends a frame
					2: nxt = '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
					// everything at its top code: saturating sizes and radius, erase
					3: nxt = '{9'h1FF, 9'h1FF, 9'h1FF, 9'h3F, 9'hFF, 9'hFF, 9'hFF, 9'h1};
					// square larger than the image, negative offsets from odd size differences
					4: nxt = '{9'd7, 9'd5, 9'd20, 9'd40, 9'($urandom_range(255)),
						9'($urandom_range(255)), 9'($urandom_range(255)), 9'd0};
					// largest legal side in a two-row image
					5: nxt = '{9'd256, 9'd2, 9'd256, 9'd50, 9'($urandom_range(255)),
						9'($urandom_range(255)), 9'($urandom_range(255)), 9'd1};
					// single column, tallest image
					6: nxt = '{9'd1, 9'd256, 9'd1, 9'd50, 9'($urandom_range(255)),
						9'($urandom_range(255)), 9'($urandom_range(255)), 9'd0};
					default: nxt = '{9'($urandom_range(20)), 9'($urandom_range(12)),
						9'($urandom_range(30)), 9'($urandom_range(63)),
						9'($urandom_range(255)), 9'($urandom_range(255)),
						9'($urandom_range(255)), 9'($urandom_range(1))};
				endcase
				for (int r = REG_IMAGE_WIDTH; r <= REG_ERASE_MODE; r++)
					write_reg(CFG_IDX_W'(r), nxt[r]);
				// a write past the register list must leave everything alone
				write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, FIRST_SPARE_INDEX)),
					CFG_DATA_W'($urandom));
				cfg_valid <= 1'b0;
				settings_used++;
			end

			if (ph < 2) begin
				foreach (corner_values[k])
					pix_pending.push_back(pix_in_t'(corner_values[k]));
			end else if (ph == 8) begin
				// hold the sender off until the block has emptied, then carry on
				queue_pixels($urandom_range(20, 35));
				wait_drained();
				queue_pixels($urandom_range(20, 35));
			end else begin
				count = $urandom_range(40, 76);
				queue_pixels(count);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (pixel_expect.size() != 0)
			flag_failure($sformatf("%0d pixels never came out", pixel_expect.size()));

		$display("checked %0d of %0d pixels over %0d register settings",
			pixels_checked, pixels_sent, settings_used);
		$display("%0d pixels fell inside the rounded square, %0d frame ends, %0d failures",
			covered_pixels, frame_ends, failures);
		if (failures == 0)
			$display("rounded_square_overlay_unit verification clean");
		else
			$display("rounded_square_overlay_unit verification failed");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("rounded_square_overlay_unit verification failed");
		$finish;
	end

endmodule
